// File: hdl/parabola_fit_three_points_top_defines.svh
// Assertion macros for the three-point parabola fit block.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef PARABOLA_FIT_THREE_POINTS_TOP_DEFINES_SVH
`define PARABOLA_FIT_THREE_POINTS_TOP_DEFINES_SVH

// same-cycle implication
`define PF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pfit_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the parabola fit block.
// No dependencies.
package pfit_pkg;
    localparam int COEF_W  = 48;
    localparam int FRAC_W  = 16;
    localparam int DEN_W   = 50;
    localparam int NUM_W   = 64;
    localparam int N_COEF  = 3;
    localparam int Q_STEPS = COEF_W;

    localparam logic [COEF_W-1:0] COEF_POS_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W:0]   COEF_POS_LIM = {2'b00, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W:0]   COEF_NEG_LIM = {2'b01, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic                  singular;
        logic [N_COEF-1:0]     neg;
        logic [DEN_W-1:0]      den;
        logic [NUM_W-1:0]      num_c;
        logic [NUM_W-1:0]      num_b;
        logic [NUM_W-1:0]      num_a;
    } job_t;
endpackage

// File: hdl/pfit_front.sv
`timescale 1ns / 1ps
// Front end: accept points, build the determinant and three numerators.
// Depends on pfit_pkg.
module pfit_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [95:0]        in_data,
    output logic               job_valid,
    input  logic               job_full,
    output pfit_pkg::job_t     job
);
    import pfit_pkg::*;

    logic [3:0] vld_reg, vld_next;
    logic       en;

    logic signed [15:0] y1_reg, y2_reg, y3_reg;
    logic signed [16:0] d12_reg, d13_reg, d23_reg;
    logic signed [31:0] sq1_reg, sq2_reg, sq3_reg, x12_reg, x13_reg, x23_reg;

    logic signed [15:0] y1_s2_reg, y2_s2_reg, y3_s2_reg;
    logic signed [16:0] d23_s2_reg;
    logic signed [33:0] pd_reg;
    logic signed [32:0] ya1_reg, ya2_reg, ya3_reg;
    logic signed [49:0] yb1_reg, yb2_reg, yb3_reg;
    logic signed [48:0] t1_reg, t2_reg, t3_reg;

    logic signed [50:0] det_reg;
    logic signed [35:0] na_reg;
    logic signed [51:0] nb_reg;
    logic signed [64:0] yc1_reg, yc2_reg, yc3_reg;

    job_t job_reg;

    logic signed [15:0] x1, x2, x3;
    logic signed [32:0] s23, s13, s12;
    logic signed [65:0] nc;
    logic signed [65:0] na_x, nb_x;
    logic signed [65:0] det_x;
    logic [65:0]        ma, mb, mc, md;

    assign x1 = in_data[15:0];
    assign x2 = in_data[47:32];
    assign x3 = in_data[79:64];

    assign en        = !vld_reg[3] || !job_full;
    assign in_ready  = en;
    assign job_valid = vld_reg[3];
    assign job       = job_reg;

    always_comb begin
        s23 = 33'(sq2_reg) - 33'(sq3_reg);
        s13 = 33'(sq1_reg) - 33'(sq3_reg);
        s12 = 33'(sq1_reg) - 33'(sq2_reg);
        nc    = 66'(yc1_reg) - 66'(yc2_reg) + 66'(yc3_reg);
        na_x  = 66'(na_reg);
        nb_x  = 66'(nb_reg);
        det_x = 66'(det_reg);
        ma = na_x[65] ? 66'(-na_x) : na_x;
        mb = nb_x[65] ? 66'(-nb_x) : nb_x;
        mc = nc[65] ? 66'(-nc) : nc;
        md = det_x[65] ? 66'(-det_x) : det_x;
        vld_next = {vld_reg[2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y1_reg  <= in_data[31:16];
            y2_reg  <= in_data[63:48];
            y3_reg  <= in_data[95:80];
            d12_reg <= 17'(x1) - 17'(x2);
            d13_reg <= 17'(x1) - 17'(x3);
            d23_reg <= 17'(x2) - 17'(x3);
            sq1_reg <= x1 * x1;
            sq2_reg <= x2 * x2;
            sq3_reg <= x3 * x3;
            x12_reg <= x1 * x2;
            x13_reg <= x1 * x3;
            x23_reg <= x2 * x3;

            y1_s2_reg  <= y1_reg;
            y2_s2_reg  <= y2_reg;
            y3_s2_reg  <= y3_reg;
            d23_s2_reg <= d23_reg;
            pd_reg  <= 34'(d12_reg) * 34'(d13_reg);
            ya1_reg <= 33'(y1_reg) * 33'(d23_reg);
            ya2_reg <= 33'(y2_reg) * 33'(d13_reg);
            ya3_reg <= 33'(y3_reg) * 33'(d12_reg);
            yb1_reg <= 50'(y1_reg) * 50'(s23);
            yb2_reg <= 50'(y2_reg) * 50'(s13);
            yb3_reg <= 50'(y3_reg) * 50'(s12);
            t1_reg  <= 49'(x23_reg) * 49'(d23_reg);
            t2_reg  <= 49'(x13_reg) * 49'(d13_reg);
            t3_reg  <= 49'(x12_reg) * 49'(d12_reg);

            det_reg <= 51'(pd_reg) * 51'(d23_s2_reg);
            na_reg  <= 36'(ya1_reg) - 36'(ya2_reg) + 36'(ya3_reg);
            nb_reg  <= 52'(yb2_reg) - 52'(yb1_reg) - 52'(yb3_reg);
            yc1_reg <= 65'(y1_s2_reg) * 65'(t1_reg);
            yc2_reg <= 65'(y2_s2_reg) * 65'(t2_reg);
            yc3_reg <= 65'(y3_s2_reg) * 65'(t3_reg);

            job_reg.singular <= (det_reg == '0);
            job_reg.neg      <= {nc[65] ^ det_reg[50], nb_reg[51] ^ det_reg[50],
                                 na_reg[35] ^ det_reg[50]};
            job_reg.den      <= md[DEN_W-1:0];
            job_reg.num_a    <= ma[NUM_W-1:0];
            job_reg.num_b    <= mb[NUM_W-1:0];
            job_reg.num_c    <= mc[NUM_W-1:0];
        end
    end
endmodule

// File: hdl/pfit_fifo.sv
`timescale 1ns / 1ps
// Short queue of fit jobs between front end and divider back end.
// Depends on pfit_pkg.
module pfit_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pfit_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output pfit_pkg::job_t head
);
    import pfit_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// File: hdl/pfit_back.sv
`timescale 1ns / 1ps
// Back end: three pipelined restoring dividers, one quotient bit per stage,
// then clip, sign and output register. Depends on pfit_pkg.
module pfit_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_empty,
    input  pfit_pkg::job_t                job,
    output logic                          job_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pfit_pkg::COEF_W-1:0]   coef_square,
    output logic [pfit_pkg::COEF_W-1:0]   coef_linear,
    output logic [pfit_pkg::COEF_W-1:0]   coef_constant,
    output logic                          singular,
    output logic                          saturated
);
    import pfit_pkg::*;

    logic                en;
    logic [Q_STEPS:0]    vld_reg;
    logic [DEN_W-1:0]    rem_reg [N_COEF][Q_STEPS+1];
    logic [COEF_W-1:0]   lq_reg  [N_COEF][Q_STEPS+1];
    logic [N_COEF-1:0]   ovf_reg [Q_STEPS+1];
    logic [N_COEF-1:0]   neg_reg [Q_STEPS+1];
    logic [DEN_W-1:0]    den_reg [Q_STEPS+1];
    logic                sing_reg [Q_STEPS+1];

    logic                out_valid_reg;
    logic [COEF_W-1:0]   coef_reg [N_COEF];
    logic                sing_out_reg, sat_out_reg;

    logic [NUM_W-1:0]    num [N_COEF];
    logic [DEN_W:0]      trial [N_COEF][Q_STEPS];
    logic                ge [N_COEF][Q_STEPS];
    logic [DEN_W-1:0]    hi0 [N_COEF];
    logic                ovf0 [N_COEF];
    logic [COEF_W:0]     lim [N_COEF];
    logic [COEF_W:0]     mag [N_COEF];
    logic [COEF_W:0]     res [N_COEF];
    logic [N_COEF-1:0]   clip;

    assign en          = !out_valid_reg || out_ready;
    assign job_pop     = en && !job_empty;
    assign out_valid   = out_valid_reg;
    assign coef_square   = coef_reg[0];
    assign coef_linear   = coef_reg[1];
    assign coef_constant = coef_reg[2];
    assign singular    = sing_out_reg;
    assign saturated   = sat_out_reg;

    always_comb begin
        num[0] = job.num_a;
        num[1] = job.num_b;
        num[2] = job.num_c;
        for (int i = 0; i < N_COEF; i++) begin
            hi0[i]  = DEN_W'(num[i][NUM_W-1:COEF_W-FRAC_W]);
            ovf0[i] = (hi0[i] >= job.den);
            for (int k = 0; k < Q_STEPS; k++) begin
                trial[i][k] = {rem_reg[i][k], lq_reg[i][k][COEF_W-1]};
                ge[i][k]    = (trial[i][k] >= {1'b0, den_reg[k]});
            end
            lim[i]  = neg_reg[Q_STEPS][i] ? COEF_NEG_LIM : COEF_POS_LIM;
            clip[i] = ovf_reg[Q_STEPS][i] || ({1'b0, lq_reg[i][Q_STEPS]} > lim[i]);
            mag[i]  = clip[i] ? lim[i] : {1'b0, lq_reg[i][Q_STEPS]};
            res[i]  = neg_reg[Q_STEPS][i] ? (COEF_W+1)'(-mag[i]) : mag[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[Q_STEPS-1:0], !job_empty};
            out_valid_reg <= vld_reg[Q_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= job.den;
            neg_reg[0]  <= job.neg;
            sing_reg[0] <= job.singular;
            for (int i = 0; i < N_COEF; i++) begin
                ovf_reg[0][i] <= ovf0[i];
                rem_reg[i][0] <= ovf0[i] ? '0 : hi0[i];
                lq_reg[i][0]  <= {num[i][COEF_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            end
            for (int k = 0; k < Q_STEPS; k++) begin
                den_reg[k+1]  <= den_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                sing_reg[k+1] <= sing_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                for (int i = 0; i < N_COEF; i++) begin
                    rem_reg[i][k+1] <= ge[i][k] ?
                        DEN_W'(trial[i][k] - {1'b0, den_reg[k]}) : DEN_W'(trial[i][k]);
                    lq_reg[i][k+1]  <= {lq_reg[i][k][COEF_W-2:0], ge[i][k]};
                end
            end
            sing_out_reg <= sing_reg[Q_STEPS];
            sat_out_reg  <= !sing_reg[Q_STEPS] && (clip != '0);
            for (int i = 0; i < N_COEF; i++) begin
                coef_reg[i] <= sing_reg[Q_STEPS] ? COEF_POS_MAX : res[i][COEF_W-1:0];
            end
        end
    end
endmodule

// File: hdl/parabola_fit_three_points_top.sv
`timescale 1ns / 1ps
// Three-point parabola fit y = a*x^2 + b*x + c by Cramer's rule.
// Slave channel s_*: one transaction per fit, three (x, y) points.
// Master channel m_*: a, b, c in Q31.16, truncated toward zero, clipped.
// Flags in m_tuser: singular when two x coordinates match, saturated when
// any coefficient was clipped. A singular fit returns all coefficients at
// the positive maximum.
// Throughput: one transaction per cycle while m_tready stays high.
// Pipeline from accept to m_tvalid: four front stages, the queue register,
// 49 divider stages (a setup stage, then one quotient bit per stage, 48
// bits), one output register.
// When m_tready is low with m_tvalid high, the divider pipeline and output
// register hold; the front end keeps filling the job queue and deasserts
// s_tready once it is full. Reset (aresetn low, synchronous) empties the
// pipeline and queue; s_tready is high from the first clock edge in reset on.
// Depends on pfit_pkg, pfit_front, pfit_fifo, pfit_back and the defines header.
`include "parabola_fit_three_points_top_defines.svh"
module parabola_fit_three_points_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_first, y_first, x_second, y_second, x_third, y_third
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // coef_square, coef_linear, coef_constant
    output logic [143:0] m_tdata,
    // singular, saturated
    output logic [1:0]   m_tuser
);
    import pfit_pkg::*;

    job_t              f_job, q_head;
    logic              f_valid, q_full, q_empty, q_pop;
    logic [COEF_W-1:0] ca, cb, cc;
    logic              sing, sat;

    pfit_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .job_valid (f_valid),
        .job_full  (q_full),
        .job       (f_job)
    );

    pfit_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_valid),
        .push_data (f_job),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    pfit_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_empty     (q_empty),
        .job           (q_head),
        .job_pop       (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .coef_square   (ca),
        .coef_linear   (cb),
        .coef_constant (cc),
        .singular      (sing),
        .saturated     (sat)
    );

    assign m_tdata = {cc, cb, ca};
    assign m_tuser = {sat, sing};

    `PF_ASSERT_NOW(a_sing_no_sat, m_tvalid && m_tuser[0], !m_tuser[1],
        "singular fit flagged as saturated")
    `PF_ASSERT_NOW(a_sing_max, m_tvalid && m_tuser[0],
        m_tdata[47:0] == COEF_POS_MAX && m_tdata[143:96] == COEF_POS_MAX,
        "singular fit without maximum coefficients")
    `PF_ASSERT_NEXT(a_full_stalls, q_full && f_valid && !q_pop, q_full,
        "job queue lost its fill while stalled")
endmodule

// File: tb/sv/parabola_fit_three_points_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the three-point parabola fit block.
// Drives point triples over s_*, predicts a, b, c and flags, checks m_*.
module parabola_fit_three_points_top_test;
    import pfit_pkg::*;

    typedef struct packed {
        logic [47:0] coef_constant;
        logic [47:0] coef_linear;
        logic [47:0] coef_square;
        logic        saturated;
        logic        singular;
    } fit_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;

    fit_t fit_queue[$];
    int   error_count;
    int   fit_count;
    int   singular_count;
    int   clip_count;
    bit   idle_en;

    parabola_fit_three_points_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("parabola_fit_three_points_top verification failed");
        $finish;
    end

    function automatic logic [47:0] q_divide(longint num, longint den, inout bit clip);
        bit       neg;
        bit [63:0] n;
        bit [63:0] d;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] lim;
        bit [63:0] m;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
        if (q >= 64'h1_0000_0000) begin
            m = lim + 1;
        end else begin
            m = (q << 16) + ((r << 16) / d);
        end
        if (m > lim) begin
            clip = 1'b1;
            m = lim;
        end
        if (neg) begin
            m = -m;
        end
        return m[47:0];
    endfunction

    function automatic fit_t fit_points(logic [95:0] pts);
        longint x1, y1, x2, y2, x3, y3, d12, d13, d23, det, na, nb, nc;
        bit     clip;
        fit_t   f;
        x1 = $signed(pts[15:0]);
        y1 = $signed(pts[31:16]);
        x2 = $signed(pts[47:32]);
        y2 = $signed(pts[63:48]);
        x3 = $signed(pts[79:64]);
        y3 = $signed(pts[95:80]);
        d12 = x1 - x2;
        d13 = x1 - x3;
        d23 = x2 - x3;
        det = d12 * d13 * d23;
        clip = 1'b0;
        if (det == 0) begin
            f.coef_square   = COEF_POS_MAX;
            f.coef_linear   = COEF_POS_MAX;
            f.coef_constant = COEF_POS_MAX;
            f.singular  = 1'b1;
            f.saturated = 1'b0;
            return f;
        end
        na = y1 * d23 - y2 * d13 + y3 * d12;
        nb = -(y1 * (x2 * x2 - x3 * x3) - y2 * (x1 * x1 - x3 * x3)
               + y3 * (x1 * x1 - x2 * x2));
        nc = y1 * (x2 * x3 * d23) - y2 * (x1 * x3 * d13) + y3 * (x1 * x2 * d12);
        f.coef_square   = q_divide(na, det, clip);
        f.coef_linear   = q_divide(nb, det, clip);
        f.coef_constant = q_divide(nc, det, clip);
        f.singular  = 1'b0;
        f.saturated = clip;
        return f;
    endfunction

    task automatic send_points(logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
                               logic [15:0] y2, logic [15:0] x3, logic [15:0] y3);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y3, x3, y2, x2, y1, x1};
        fit_queue.push_back(fit_points({y3, x3, y2, x2, y1, x1}));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (fit_queue.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 16'(16'h8000 + $urandom_range(0, 3));
            1: return 16'(16'h7FFF - $urandom_range(0, 3));
            2: return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_points(16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0002, 16'h0004);
        send_points(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_points(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF);
        send_points(16'h0005, 16'h0003, 16'h0005, 16'h0009, 16'h0007, 16'h0001);
        send_points(16'h0001, 16'h0003, 16'h0002, 16'h0009, 16'h0001, 16'h0001);
        send_points(16'h0003, 16'h0003, 16'h0003, 16'h0003, 16'h0003, 16'h0003);
        send_points(16'h0000, 16'h7FFF, 16'h0001, 16'h8000, 16'h0002, 16'h7FFF);
        send_points(16'h0000, 16'h8000, 16'h0001, 16'h7FFF, 16'h0002, 16'h8000);
        send_points(16'h0000, 16'h0001, 16'h0003, 16'h0000, 16'hFFFD, 16'h0000);
        send_points(16'h7FFE, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_points(16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
        send_points(16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001);
        send_points(16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            send_points(pick_coord(), 16'($urandom), pick_coord(), 16'($urandom),
                        pick_coord(), 16'($urandom));
        end
    endtask

    task automatic test_close_x(int count);
        logic [15:0] base;
        for (int i = 0; i < count; i++) begin
            base = 16'($urandom);
            send_points(base, 16'($urandom), 16'(base + $urandom_range(0, 2)),
                        16'($urandom), 16'(base - $urandom_range(0, 2)),
                        16'($urandom));
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!idle_en) begin
                m_tready <= 1'b1;
            end else if (m_tready && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        fit_t want;
        fit_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.coef_square   = m_tdata[47:0];
                got.coef_linear   = m_tdata[95:48];
                got.coef_constant = m_tdata[143:96];
                got.singular  = m_tuser[0];
                got.saturated = m_tuser[1];
                if (fit_queue.size() == 0) begin
                    $display("%0t unexpected result: %h", $time, got);
                    error_count++;
                end else begin
                    want = fit_queue.pop_front();
                    fit_count++;
                    singular_count += want.singular;
                    clip_count += want.saturated;
                    if (got.coef_square !== want.coef_square) begin
                        $display("%0t coef_square: expected %h actual %h", $time,
                                 want.coef_square, got.coef_square);
                        error_count++;
                    end
                    if (got.coef_linear !== want.coef_linear) begin
                        $display("%0t coef_linear: expected %h actual %h", $time,
                                 want.coef_linear, got.coef_linear);
                        error_count++;
                    end
                    if (got.coef_constant !== want.coef_constant) begin
                        $display("%0t coef_constant: expected %h actual %h", $time,
                                 want.coef_constant, got.coef_constant);
                        error_count++;
                    end
                    if (got.singular !== want.singular) begin
                        $display("%0t singular: expected %b actual %b", $time,
                                 want.singular, got.singular);
                        error_count++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $display("%0t saturated: expected %b actual %b", $time,
                                 want.saturated, got.saturated);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        error_count = 0;
        fit_count = 0;
        singular_count = 0;
        clip_count = 0;
        idle_en = 1'b1;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(900);
        wait_drained();
        test_close_x(450);
        idle_en = 1'b0;
        test_random(400);
        wait_drained();
        $display("covered %0d fits: %0d singular, %0d clipped", fit_count,
                 singular_count, clip_count);
        if (error_count == 0) begin
            $display("parabola_fit_three_points_top verification clean");
        end else begin
            $display("parabola_fit_three_points_top verification failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hdl
hdl/pfit_pkg.sv
hdl/pfit_front.sv
hdl/pfit_fifo.sv
hdl/pfit_back.sv
hdl/parabola_fit_three_points_top.sv
tb/sv/parabola_fit_three_points_top_test.sv
